// ===== hdl/iig_pkg.sv =====
package iig_pkg;

   // Register families tracked by the hazard masks. Bits at or above this
   // count are ignored.
   localparam int REG_SLOTS = 32;
   localparam int MASK_WIDTH = 32;
   localparam logic [MASK_WIDTH-1:0] SLOT_MASK =
      (REG_SLOTS >= MASK_WIDTH) ? {MASK_WIDTH{1'b1}}
                                : MASK_WIDTH'((64'd1 << REG_SLOTS) - 64'd1);

   // Result queue between the grouping logic and the result channel.
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_WIDTH = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_WIDTH = $clog2(RSP_DEPTH + 1);

   typedef struct packed {
      logic [31:0] read_mask;
      logic [31:0] write_mask;
      logic        writes_memory;
      logic        touches_pc_or_unknown;
      logic        is_jump_target;
      logic [31:0] prior_group;
      logic        prior_reorderable;
      logic        is_last;
   } req_type;

   typedef struct packed {
      logic [31:0] group;
      logic        reorderable;
      logic        last;
      logic [31:0] counter_after;
   } rsp_type;

endpackage

// ===== hdl/independent_instruction_grouper_core.sv =====
// Independent instruction grouper.
// Decoded instructions arrive as beats on the req_ channel (valid/ready).
// Each one is assigned to a group of mutually independent instructions by
// checking its read and write register masks against the running masks of
// the current group (RAW, WAR and WAW hazards). Results leave as beats on
// the rsp_ channel (valid/ready), in input order.
// Because an isolated reorderable instruction is demoted to group 0, a
// result needs to see the following instruction: the result for an item is
// produced when the next item is processed, and the item flagged is_last
// flushes its own result and, if one is held, that of its predecessor.
// Timing: an accepted beat is registered, then processed and written into
// a four-entry result queue once the queue has room for two results. One
// instruction is taken every cycle while the queue has that room; the input
// register advances whenever the queue has room for two results.
// When the receiver stalls, the queue fills and then the input register
// holds, so req_ready drops; nothing is lost.
// Synchronous reset empties the queue and the input register, clears the
// masks and the held instruction and sets the group counter to zero.
// csr_we with csr_wdata loads the group counter; write it only while idle.
module independent_instruction_grouper_core
   import iig_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,

   input  logic        csr_we,
   input  logic [31:0] csr_wdata
);

   // Input register.
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // Grouping state.
   logic [MASK_WIDTH-1:0] read_regs_ff, read_regs_in;
   logic [MASK_WIDTH-1:0] written_regs_ff, written_regs_in;
   logic [31:0] group_counter_ff, group_counter_in;
   logic [31:0] held_group_ff, held_group_in;
   logic        held_reorderable_ff, held_reorderable_in;
   logic        held_valid_ff, held_valid_in;
   logic [31:0] before_held_group_ff, before_held_group_in;
   logic        held_is_first_ff, held_is_first_in;

   // Result queue.
   rsp_type                  rsp_queue_ff [RSP_DEPTH];
   logic [RSP_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_WIDTH-1:0] count_ff, count_in;

   // Processing signals.
   logic                  fire;
   logic                  pop;
   logic [MASK_WIDTH-1:0] rd_mask, wr_mask, eff_rd, eff_wr;
   logic                  hazard, conflict, plain;
   logic [1:0]            inc;
   logic [31:0]           counter_new;
   logic [31:0]           cur_group;
   logic                  cur_reord;
   logic [31:0]           emit1_group;
   logic                  emit1_reord;
   logic                  first2;
   logic [31:0]           before2;
   logic [31:0]           emit2_group;
   logic                  emit2_reord;
   logic                  push1, push2;
   rsp_type               entry1, entry2;
   logic [RSP_PTR_WIDTH-1:0] wr_ptr2;

   // A beat is processed only when the queue can take the worst case of two.
   assign fire      = in_valid_ff && (count_ff <= RSP_CNT_WIDTH'(RSP_DEPTH - 2));
   assign req_ready = !in_valid_ff || fire;
   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = rsp_queue_ff[rd_ptr_ff];
   assign pop       = rsp_valid && rsp_ready;

   always_comb begin
      rd_mask = in_data_ff.read_mask & SLOT_MASK;
      wr_mask = in_data_ff.write_mask & SLOT_MASK;

      // A new sequence or a jump target starts from empty masks.
      if (held_valid_ff && !in_data_ff.is_jump_target) begin
         eff_rd = read_regs_ff;
         eff_wr = written_regs_ff;
      end else begin
         eff_rd = '0;
         eff_wr = '0;
      end

      hazard = (|((rd_mask | wr_mask) & eff_wr)) || (|(wr_mask & (eff_wr | eff_rd)));
      plain    = !in_data_ff.writes_memory && !in_data_ff.touches_pc_or_unknown;
      conflict = hazard || !plain;

      if (in_data_ff.prior_group != '0) begin
         // An instruction that already has a group keeps it and closes the run.
         inc             = 2'(!held_valid_ff) + 2'd1;
         counter_new     = group_counter_ff + 32'(inc);
         cur_group       = in_data_ff.prior_group;
         cur_reord       = in_data_ff.prior_reorderable;
         read_regs_in    = '0;
         written_regs_in = '0;
      end else begin
         inc = 2'(!held_valid_ff) + 2'(in_data_ff.is_jump_target) + 2'(conflict);
         counter_new = group_counter_ff + 32'(inc);
         if (!conflict) begin
            read_regs_in    = eff_rd | rd_mask;
            written_regs_in = eff_wr | wr_mask;
            cur_group       = counter_new;
            cur_reord       = 1'b1;
         end else if (plain) begin
            read_regs_in    = rd_mask;
            written_regs_in = wr_mask;
            cur_group       = counter_new;
            cur_reord       = 1'b1;
         end else begin
            read_regs_in    = '0;
            written_regs_in = '0;
            cur_group       = '0;
            cur_reord       = 1'b0;
         end
      end

      // Held instruction, with the current one as its successor.
      if (held_reorderable_ff && (held_is_first_ff || before_held_group_ff != held_group_ff)
          && (cur_group != held_group_ff)) begin
         emit1_group = '0;
         emit1_reord = 1'b0;
      end else begin
         emit1_group = held_group_ff;
         emit1_reord = held_reorderable_ff;
      end

      // Current instruction when it ends the sequence (no successor).
      first2  = held_valid_ff ? 1'b0 : held_is_first_ff;
      before2 = held_valid_ff ? emit1_group : before_held_group_ff;
      if (cur_reord && (first2 || before2 != cur_group)) begin
         emit2_group = '0;
         emit2_reord = 1'b0;
      end else begin
         emit2_group = cur_group;
         emit2_reord = cur_reord;
      end

      entry1.group         = emit1_group;
      entry1.reorderable   = emit1_reord;
      entry1.last          = 1'b0;
      entry1.counter_after = '0;
      entry2.group         = emit2_group;
      entry2.reorderable   = emit2_reord;
      entry2.last          = 1'b1;
      entry2.counter_after = counter_new;

      push1 = fire && held_valid_ff;
      push2 = fire && in_data_ff.is_last;

      group_counter_in = counter_new;
      if (in_data_ff.is_last) begin
         held_valid_in        = 1'b0;
         held_is_first_in     = 1'b1;
         before_held_group_in = '0;
         held_group_in        = '0;
         held_reorderable_in  = 1'b0;
      end else begin
         held_valid_in        = 1'b1;
         held_is_first_in     = first2;
         before_held_group_in = before2;
         held_group_in        = cur_group;
         held_reorderable_in  = cur_reord;
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_ready) begin
         in_valid_in = req_valid;
      end
      wr_ptr2   = wr_ptr_ff + RSP_PTR_WIDTH'(push1);
      wr_ptr_in = wr_ptr2 + RSP_PTR_WIDTH'(push2);
      rd_ptr_in = rd_ptr_ff + RSP_PTR_WIDTH'(pop);
      count_in  = count_ff + RSP_CNT_WIDTH'(push1) + RSP_CNT_WIDTH'(push2)
                  - RSP_CNT_WIDTH'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff          <= 1'b0;
         wr_ptr_ff            <= '0;
         rd_ptr_ff            <= '0;
         count_ff             <= '0;
         read_regs_ff         <= '0;
         written_regs_ff      <= '0;
         group_counter_ff     <= '0;
         held_group_ff        <= '0;
         held_reorderable_ff  <= 1'b0;
         held_valid_ff        <= 1'b0;
         before_held_group_ff <= '0;
         held_is_first_ff     <= 1'b1;
      end else begin
         in_valid_ff <= in_valid_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         count_ff    <= count_in;
         if (fire) begin
            read_regs_ff         <= in_data_ff.is_last ? '0 : read_regs_in;
            written_regs_ff      <= in_data_ff.is_last ? '0 : written_regs_in;
            group_counter_ff     <= group_counter_in;
            held_group_ff        <= held_group_in;
            held_reorderable_ff  <= held_reorderable_in;
            held_valid_ff        <= held_valid_in;
            before_held_group_ff <= before_held_group_in;
            held_is_first_ff     <= held_is_first_in;
         end else if (csr_we) begin
            group_counter_ff <= csr_wdata;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_data_ff <= req_data;
      end
      if (push1) begin
         rsp_queue_ff[wr_ptr_ff] <= entry1;
      end
      if (push2) begin
         rsp_queue_ff[wr_ptr2] <= entry2;
      end
   end

   // The queue never holds more than its depth.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= RSP_CNT_WIDTH'(RSP_DEPTH))
      else $error("result queue overflow");

   // Processing only happens with room for two results.
   assert property (@(posedge clock) disable iff (reset)
      fire |-> (count_ff + RSP_CNT_WIDTH'(2) <= RSP_CNT_WIDTH'(RSP_DEPTH)))
      else $error("processed without queue room");

   // The final instruction always leaves nothing held.
   assert property (@(posedge clock) disable iff (reset)
      fire && in_data_ff.is_last |=> !held_valid_ff && held_is_first_ff)
      else $error("held instruction survived end of sequence");

   // Only a final result carries the counter value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.counter_after == '0)
      else $error("counter reported on a non-final result");

endmodule
